>>> rtl/sort_unique_integers_core_defines.svh
// Assertion macros shared by the sort-unique core modules.
`ifndef SORT_UNIQUE_INTEGERS_CORE_DEFINES_SVH
`define SORT_UNIQUE_INTEGERS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SUI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SUI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sui_pkg.sv
// Shared constants, types and control structs of the sort-unique core.
package sui_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_WIDTH  = $clog2(MAX_ITEMS);
    localparam int COUNT_WIDTH = 7;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_WIDTH-1:0]         addr_t;
    typedef logic [COUNT_WIDTH-1:0]        count_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;          // capture input word, read top of the sorted list
        logic shift;         // move the read entry up one place, read the one below
        logic insert_above;  // write the new word above the read entry
        logic insert_bottom; // write the new word at the bottom of the list
        logic emit_start;    // read the smallest entry
        logic skip;          // drop a duplicate, read the next entry
        logic emit;          // load the output register, read the next entry
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic greater;
        logic equal;
        logic idx_zero;
        logic dup;
        logic out_free;
        logic final_word;
    } status_t;

endpackage

>>> rtl/sui_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sui_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/sui_datapath.sv
// Datapath: sorted value store, counters, compare logic and output register.
`include "sort_unique_integers_core_defines.svh"

module sui_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sui_pkg::value_t   s_value,
    input  sui_pkg::cmd_t     cmd,
    output sui_pkg::status_t  status,
    output logic              m_valid,
    input  logic              m_ready,
    output sui_pkg::value_t   m_unique_value,
    output sui_pkg::count_t   m_unique_count,
    output logic              m_is_last,
    output logic              m_overflow
);

    sui_pkg::value_t value_reg, value_next;
    sui_pkg::value_t prev_reg, prev_next;
    sui_pkg::addr_t  idx_reg, idx_next;
    sui_pkg::count_t stored_cnt_reg, stored_cnt_next;
    sui_pkg::count_t uniq_cnt_reg, uniq_cnt_next;
    sui_pkg::count_t emitted_reg, emitted_next;
    logic            ovf_reg, ovf_next;
    logic            m_valid_reg, m_valid_next;
    sui_pkg::value_t out_value_reg, out_value_next;
    sui_pkg::count_t out_count_reg, out_count_next;
    logic            out_last_reg, out_last_next;
    logic            out_ovf_reg, out_ovf_next;

    logic            ram_we;
    sui_pkg::addr_t  ram_waddr;
    sui_pkg::value_t ram_wdata;
    logic            ram_re;
    sui_pkg::addr_t  ram_raddr;
    sui_pkg::value_t ram_rdata;

    sui_ram #(
        .WIDTH (sui_pkg::VALUE_WIDTH),
        .DEPTH (sui_pkg::MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        status.full       = (stored_cnt_reg == sui_pkg::count_t'(sui_pkg::MAX_ITEMS));
        status.empty      = (stored_cnt_reg == '0);
        status.greater    = (ram_rdata > value_reg);
        status.equal      = (ram_rdata == value_reg);
        status.idx_zero   = (idx_reg == '0);
        status.dup        = (idx_reg != '0) && (ram_rdata == prev_reg);
        status.out_free   = !m_valid_reg || m_ready;
        status.final_word = (sui_pkg::count_t'(emitted_reg + 1'b1) == uniq_cnt_reg);
    end

    always_comb begin
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = value_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        value_next      = value_reg;
        prev_next       = prev_reg;
        idx_next        = idx_reg;
        stored_cnt_next = stored_cnt_reg;
        uniq_cnt_next   = uniq_cnt_reg;
        emitted_next    = emitted_reg;
        ovf_next        = ovf_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        if (cmd.take) begin
            value_next = s_value;
            idx_next   = sui_pkg::addr_t'(stored_cnt_reg - 1'b1);
            ram_re     = 1'b1;
            ram_raddr  = sui_pkg::addr_t'(stored_cnt_reg - 1'b1);
            if (status.full) begin
                ovf_next = 1'b1;
            end
        end

        if (cmd.shift) begin
            ram_we    = 1'b1;
            ram_waddr = sui_pkg::addr_t'(idx_reg + 1'b1);
            ram_wdata = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = sui_pkg::addr_t'(idx_reg - 1'b1);
            idx_next  = sui_pkg::addr_t'(idx_reg - 1'b1);
        end

        if (cmd.insert_above) begin
            ram_we          = 1'b1;
            ram_waddr       = sui_pkg::addr_t'(idx_reg + 1'b1);
            ram_wdata       = value_reg;
            stored_cnt_next = sui_pkg::count_t'(stored_cnt_reg + 1'b1);
            if (!status.equal) begin
                uniq_cnt_next = sui_pkg::count_t'(uniq_cnt_reg + 1'b1);
            end
        end

        if (cmd.insert_bottom) begin
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata       = value_reg;
            stored_cnt_next = sui_pkg::count_t'(stored_cnt_reg + 1'b1);
            uniq_cnt_next   = sui_pkg::count_t'(uniq_cnt_reg + 1'b1);
        end

        if (cmd.emit_start) begin
            ram_re       = 1'b1;
            ram_raddr    = '0;
            idx_next     = '0;
            emitted_next = '0;
        end

        if (cmd.skip || cmd.emit) begin
            ram_re    = 1'b1;
            ram_raddr = sui_pkg::addr_t'(idx_reg + 1'b1);
            idx_next  = sui_pkg::addr_t'(idx_reg + 1'b1);
        end

        if (cmd.emit) begin
            m_valid_next   = 1'b1;
            out_value_next = ram_rdata;
            out_count_next = uniq_cnt_reg;
            out_last_next  = status.final_word;
            out_ovf_next   = ovf_reg;
            prev_next      = ram_rdata;
            emitted_next   = sui_pkg::count_t'(emitted_reg + 1'b1);
            // Close the set as its largest distinct word is loaded for output.
            if (status.final_word) begin
                stored_cnt_next = '0;
                uniq_cnt_next   = '0;
                emitted_next    = '0;
                ovf_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_cnt_reg <= '0;
            uniq_cnt_reg   <= '0;
            emitted_reg    <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            stored_cnt_reg <= stored_cnt_next;
            uniq_cnt_reg   <= uniq_cnt_next;
            emitted_reg    <= emitted_next;
            ovf_reg        <= ovf_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        prev_reg      <= prev_next;
        idx_reg       <= idx_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_unique_value = out_value_reg;
    assign m_unique_count = out_count_reg;
    assign m_is_last      = out_last_reg;
    assign m_overflow     = out_ovf_reg;

    `SUI_ASSERT_IMPL(a_uniq_within_stored, 1'b1, uniq_cnt_reg <= stored_cnt_reg, "distinct count exceeds stored count")
    `SUI_ASSERT_IMPL(a_emit_into_free_reg, cmd.emit, status.out_free, "result loaded over a word not yet taken")
    `SUI_ASSERT_NEXT(a_final_clears_set, cmd.emit && status.final_word, stored_cnt_reg == '0 && m_valid && m_is_last, "set not closed after final word")

endmodule

>>> rtl/sui_ctrl.sv
// Controller: sequences insertion into the sorted store and emission of distinct words.
`include "sort_unique_integers_core_defines.svh"

module sui_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  sui_pkg::status_t  status,
    output sui_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_START,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_pend_reg, last_pend_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.take       = 1'b1;
                    last_pend_next = s_last;
                    if (status.full) begin
                        state_next = s_last ? ST_EMIT_START : ST_IDLE;
                    end else if (status.empty) begin
                        state_next = ST_PLACE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (status.greater) begin
                    cmd.shift = 1'b1;
                    if (status.idx_zero) begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    cmd.insert_above = 1'b1;
                    state_next       = last_pend_reg ? ST_EMIT_START : ST_IDLE;
                end
            end
            ST_PLACE: begin
                cmd.insert_bottom = 1'b1;
                state_next        = last_pend_reg ? ST_EMIT_START : ST_IDLE;
            end
            ST_EMIT_START: begin
                cmd.emit_start = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.dup) begin
                    cmd.skip = 1'b1;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.final_word) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

    `SUI_ASSERT_NEXT(a_busy_after_store, accept && !status.full, !s_ready, "ready held high after storing a word")

endmodule

>>> rtl/sort_unique_integers_core.sv
// Top level of the sort-and-deduplicate core: controller plus datapath.
//
//  Channel | Ports                                                    | Direction
//  --------+----------------------------------------------------------+----------
//  input   | s_valid s_ready s_value s_last                           | in
//  result  | m_valid m_ready m_unique_value m_unique_count m_is_last  | out
//          | m_overflow                                               |
//
// Each word is compared down from the top of the store; every held entry larger
// than it moves up one place, as the single RAM read port shifts one entry per
// cycle; a word that meets a full store is dropped. Closing a set reads the
// smallest entry, then walks the stored entries while the result side takes
// words; input reopens once the final word is loaded. Reset needs no clearing
// pass. A stalled result side holds the walk, but duplicates are still skipped.
module sort_unique_integers_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sui_pkg::value_t   s_value,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output sui_pkg::value_t   m_unique_value,
    output sui_pkg::count_t   m_unique_count,
    output logic              m_is_last,
    output logic              m_overflow
);

    // Command and status bundles between the controller and the datapath.
    sui_pkg::cmd_t    cmd;
    sui_pkg::status_t status;

    // Controller: accepts words, steps the insertion scan and the emission walk.
    sui_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: sorted store, counters, duplicate compare and result register.
    sui_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_value        (s_value),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_unique_value (m_unique_value),
        .m_unique_count (m_unique_count),
        .m_is_last      (m_is_last),
        .m_overflow     (m_overflow)
    );

endmodule
